[rtl/ctt_pkg.sv]
`timescale 1ns / 1ps

package ctt_pkg;

    // Token length limit and the field widths that follow from it.
    localparam int TOKEN_MAX = 1024;
    localparam int CNT_W     = 11;
    localparam int POS_W     = 10;
    localparam int RES_MAX   = 3;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TOKEN_MAX);

    // Characters that steer the scanner.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        MODE_GAP    = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4,
        MODE_QUOTE  = 3'd5,
        MODE_WORD   = 3'd6,
        MODE_AFTERQ = 3'd7
    } mode_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       ch;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] len;
        logic             disc;
        logic             quoted;
    } result_t;

    // Scanner state plus the results gathered for one byte.
    typedef struct packed {
        mode_t                     mode;
        logic [CNT_W-1:0]          cnt;
        logic [1:0]                n;
        result_t [RES_MAX-1:0]     res;
    } scan_t;

    function automatic logic is_space(logic [7:0] b);
        return (b <= CH_SPACE) || b[7];
    endfunction

    function automatic scan_t f_keep(scan_t s, logic [7:0] b, logic quoted);
        scan_t r;
        r = s;
        if (s.cnt < CNT_LIMIT) begin
            r.res[s.n] = '{kind: KIND_CHAR, ch: b, pos: s.cnt[POS_W-1:0],
                           len: '0, disc: 1'b0, quoted: quoted};
            r.n   = s.n + 2'd1;
            r.cnt = s.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic scan_t f_end_word(scan_t s);
        scan_t r;
        logic  disc;
        r    = s;
        disc = (s.cnt >= CNT_LIMIT);
        r.res[s.n] = '{kind: KIND_END, ch: '0, pos: '0,
                       len: disc ? '0 : s.cnt, disc: disc, quoted: 1'b0};
        r.n    = s.n + 2'd1;
        r.cnt  = '0;
        r.mode = MODE_GAP;
        return r;
    endfunction

    function automatic scan_t f_end_quote(scan_t s, mode_t next_mode);
        scan_t r;
        r = s;
        r.res[s.n] = '{kind: KIND_END, ch: '0, pos: '0,
                       len: s.cnt, disc: 1'b0, quoted: 1'b1};
        r.n    = s.n + 2'd1;
        r.cnt  = '0;
        r.mode = next_mode;
        return r;
    endfunction

    function automatic scan_t f_word_more(scan_t s, logic [7:0] b);
        if (!is_space(b) && b != CH_COMMA) begin
            return f_keep(s, b, 1'b0);
        end
        return f_end_word(s);
    endfunction

    function automatic scan_t f_gap(scan_t s, logic [7:0] b);
        scan_t r;
        r = s;
        if (is_space(b)) begin
            r.mode = MODE_GAP;
        end else if (b == CH_SLASH) begin
            r.mode = MODE_SLASH;
        end else if (b == CH_QUOTE) begin
            r.mode = MODE_QUOTE;
            r.cnt  = '0;
        end else begin
            r.mode = MODE_WORD;
            r.cnt  = '0;
            r      = f_keep(r, b, 1'b0);
        end
        return r;
    endfunction

endpackage

[rtl/ctt_step.sv]
`timescale 1ns / 1ps

module ctt_step (
    input  ctt_pkg::mode_t              mode,
    input  logic [ctt_pkg::CNT_W-1:0]   cnt,
    input  logic [7:0]                  text_byte,
    input  logic                        final_byte,
    output ctt_pkg::scan_t              scan
);
    import ctt_pkg::*;

    scan_t s;

    // Next mode, count and results for one byte.
    always_comb begin
        s      = '0;
        s.mode = mode;
        s.cnt  = cnt;
        s.n    = 2'd0;
        unique case (mode)
            MODE_GAP: begin
                s = f_gap(s, text_byte);
            end
            MODE_AFTERQ: begin
                if (text_byte == CH_COMMA) begin
                    s.mode = MODE_GAP;
                end else begin
                    s = f_gap(s, text_byte);
                end
            end
            MODE_SLASH: begin
                if (text_byte == CH_SLASH) begin
                    s.mode = MODE_LINE;
                end else if (text_byte == CH_STAR) begin
                    s.mode = MODE_STAR;
                end else begin
                    s.mode = MODE_WORD;
                    s.cnt  = '0;
                    s      = f_keep(s, CH_SLASH, 1'b0);
                    s      = f_word_more(s, text_byte);
                end
            end
            MODE_LINE: begin
                if (text_byte == CH_NUL || text_byte == CH_LF) begin
                    s.mode = MODE_GAP;
                end
            end
            MODE_BLOCK: begin
                if (text_byte == CH_NUL) begin
                    s.mode = MODE_GAP;
                end else if (text_byte == CH_STAR) begin
                    s.mode = MODE_STAR;
                end
            end
            MODE_STAR: begin
                if (text_byte == CH_NUL || text_byte == CH_SLASH) begin
                    s.mode = MODE_GAP;
                end else if (text_byte != CH_STAR) begin
                    s.mode = MODE_BLOCK;
                end
            end
            MODE_QUOTE: begin
                if (text_byte == CH_QUOTE) begin
                    s = f_end_quote(s, MODE_AFTERQ);
                end else if (text_byte == CH_NUL) begin
                    s = f_end_quote(s, MODE_GAP);
                end else begin
                    s = f_keep(s, text_byte, 1'b1);
                end
            end
            MODE_WORD: begin
                s = f_word_more(s, text_byte);
            end
            default: begin
                s.mode = MODE_GAP;
            end
        endcase

        // Close whatever is open on the last byte of the text.
        if (final_byte) begin
            if (s.mode == MODE_WORD) begin
                s = f_end_word(s);
            end else if (s.mode == MODE_QUOTE) begin
                s = f_end_quote(s, MODE_GAP);
            end else if (s.mode == MODE_SLASH) begin
                s.cnt = '0;
                s     = f_keep(s, CH_SLASH, 1'b0);
                s     = f_end_word(s);
            end
            s.mode = MODE_GAP;
            s.cnt  = '0;
        end
    end

    assign scan = s;

endmodule

[rtl/ctt_outbuf.sv]
`timescale 1ns / 1ps

module ctt_outbuf (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          load,
    input  logic [1:0]                                    load_count,
    input  ctt_pkg::result_t [ctt_pkg::RES_MAX-1:0]       load_res,
    output logic                                          can_load,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output ctt_pkg::result_t                              m_res,
    output logic                                          m_last
);
    import ctt_pkg::*;

    result_t [RES_MAX-1:0] buf_reg;
    logic [1:0]            rem_reg, rem_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  pop;

    assign m_valid  = (rem_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign m_last   = (rem_reg == 2'd1);
    assign m_res    = buf_reg[idx_reg];
    // Take a new group once the buffer is empty or its final result leaves now.
    assign can_load = (rem_reg == 2'd0) || (m_last && m_ready);

    always_comb begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (pop) begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
        if (load) begin
            rem_next = load_count;
            idx_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= load_res;
        end
    end

endmodule

[rtl/comma_text_tokenizer.sv]
`timescale 1ns / 1ps

// Byte-stream tokenizer. Feed the text one byte per transfer on s_, with
// s_final_byte set on the last byte (a zero byte also ends the text). Between
// tokens the block skips whitespace (0x00-0x20 and 0x80-0xFF), // line
// comments and /* block */ comments; the opening star may itself close a
// comment, so "/*/" is a complete comment. A quoted token runs to the closing
// double quote and keeps at most 1024 characters; a comma right after the
// closing quote is consumed. A word ends at whitespace or a comma, which is
// consumed; a word that reaches 1024 characters ends flagged as discarded
// with length zero. Each kept character leaves on m_ as a character transfer
// with its position in the token, and each token closes with an end transfer
// carrying its length. m_last_result marks the last result a byte caused.
// Rate: a byte is taken every cycle as long as each byte yields at most one
// result and m_ready does not stall the output; a byte that yields k results
// (k up to 3) holds off the next byte, which is taken in the cycle its final
// result leaves. The first result of a byte is registered in the single
// result buffer behind the scanner logic and is offered in the next cycle.
module comma_text_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_token_char,
    output logic [9:0]  m_char_position,
    output logic [10:0] m_token_length,
    output logic        m_token_discarded,
    output logic        m_was_quoted,
    output logic        m_last_result
);
    import ctt_pkg::*;

    mode_t             mode_reg;
    logic [CNT_W-1:0]  cnt_reg;
    scan_t             scan;
    logic              accept;
    result_t           out_res;

    ctt_step u_step (
        .mode       (mode_reg),
        .cnt        (cnt_reg),
        .text_byte  (s_text_byte),
        .final_byte (s_final_byte),
        .scan       (scan)
    );

    assign accept = s_valid && s_ready;

    // Advance the scanner state on every accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_GAP;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= scan.mode;
            cnt_reg  <= scan.cnt;
        end
    end

    // Hold the results of one byte and hand them out one transfer at a time.
    ctt_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .load_count (scan.n),
        .load_res   (scan.res),
        .can_load   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (out_res),
        .m_last     (m_last_result)
    );

    assign m_result_kind     = out_res.kind;
    assign m_token_char      = out_res.ch;
    assign m_char_position   = out_res.pos;
    assign m_token_length    = out_res.len;
    assign m_token_discarded = out_res.disc;
    assign m_was_quoted      = out_res.quoted;

endmodule

[rtl/ctt_checker.sv]
`timescale 1ns / 1ps

module ctt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [7:0]  m_token_char,
    input logic [9:0]  m_char_position,
    input logic [10:0] m_token_length,
    input logic        m_token_discarded,
    input logic        m_was_quoted,
    input logic        m_last_result
);
    import ctt_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_char)
            && $stable(m_token_length) && $stable(m_last_result))
        else $error("stalled result changed");

    // Results of one byte follow without a gap.
    a_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> m_valid)
        else $error("result group broken");

    // No new byte while a result other than the last of its group waits.
    a_noload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_result |-> !s_ready)
        else $error("byte taken while results pending");

    // End results carry no character; character results carry no length.
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind == KIND_END)
            ? (m_token_char == 8'd0 && m_char_position == 10'd0)
            : (m_token_length == 11'd0 && !m_token_discarded))
        else $error("result fields inconsistent");

    // A discarded word has zero length and was not quoted.
    a_disc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_discarded |-> m_token_length == 11'd0 && !m_was_quoted
            && m_result_kind == KIND_END)
        else $error("discarded token malformed");

endmodule

bind comma_text_tokenizer ctt_checker u_ctt_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_result_kind     (m_result_kind),
    .m_token_char      (m_token_char),
    .m_char_position   (m_char_position),
    .m_token_length    (m_token_length),
    .m_token_discarded (m_token_discarded),
    .m_was_quoted      (m_was_quoted),
    .m_last_result     (m_last_result)
);
